// ===== design/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants for the pressure/temperature compensation core.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int unsigned CalWidth = 48;
  localparam int unsigned IdxWidth = 2;

  localparam logic [IdxWidth-1:0] RegTempCal  = 2'd0;
  localparam logic [IdxWidth-1:0] RegPressCalA = 2'd1;
  localparam logic [IdxWidth-1:0] RegPressCalB = 2'd2;
  localparam logic [IdxWidth-1:0] RegPressCalC = 2'd3;

  localparam logic CmdTemp  = 1'b0;
  localparam logic CmdPress = 1'b1;

  typedef struct packed {
    logic        command;
    logic [19:0] raw_sample;
  } in_word_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_pa;
    logic               divisor_zero;
  } out_word_t;

  // Datapath micro-operations issued by the controller
  typedef enum logic [4:0] {
    OpNone,
    OpTLoad,  // a = sar(adc,3)-2*t1, b = t2 ; d = sar(adc,4)-t1
    OpT1,     // x1 = sar(a*b,11) ; a=d, b=d
    OpT2,     // a = sar(prod,12), b = t3
    OpT3,     // t_fine = x1 + sar(prod,14); a = t_fine, b = 5
    OpT4,     // temp = sar(prod+128,8)
    OpPLoad,  // x1 = sar(tfine,1)-64000 ; a=b=sar(x1,2)
    OpP1,     // sq = prod ; a = sar(sq,11), b = p6
    OpP2,     // x2 = prod ; a = x1, b = p5
    OpP3,     // x2 = sar(x2 + 2*prod,2) + p4<<16 ; a = p3, b = sar(sq,13)
    OpP4,     // y = sar(prod,3) ; a = p2, b = x1
    OpP5,     // y = sar(y + sar(prod,1),18) + 32768 ; a = y, b = p1
    OpP6,     // y = sar(prod,15) ; a = (1048576-adc)-sar(x2,12), b = 3125
    OpP7,     // dividend = prod ; set up divide
    OpDiv,    // one restoring divide step
    OpP8,     // p = quotient fixup ; a = b = p>>3
    OpP9,     // a = prod>>13, b = p9
    OpP10,    // x1 = sar(prod,12) ; a = p>>2, b = p8
    OpP11     // pressure = p + sar(x1 + sar(prod,13) + p7,4)
  } op_e;

  typedef struct packed {
    logic div_zero;
  } dp_status_t;

  function automatic logic [31:0] sar32(input logic [31:0] x, input int unsigned n);
    logic signed [31:0] s;
    s = $signed(x);
    return 32'(s >>> n);
  endfunction

  function automatic logic [31:0] sw(input logic [CalWidth-1:0] r, input int unsigned k);
    logic [15:0] w;
    w = r[16*k +: 16];
    return {{16{w[15]}}, w};
  endfunction

endpackage

// ===== design/ptc_datapath.sv =====
// ----------------------------------------------------------------------------
// ptc_datapath
// Shared 32x32 multiplier, operand registers, serial divider and result regs.
// ----------------------------------------------------------------------------
module ptc_datapath import ptc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [IdxWidth-1:0] cfg_idx_i,
  input  logic [CalWidth-1:0] cfg_data_i,
  input  logic                load_i,
  input  logic [19:0]         raw_i,
  input  op_e                 op_i,
  output dp_status_t          status_o,
  output out_word_t           result_o
);

  logic [CalWidth-1:0] tcal_q, pca_q, pcb_q, pcc_q;
  logic [31:0] a_q, b_q, x1_q, x2_q, sq_q, y_q, p_q, tfine_q;
  logic [31:0] prod;
  logic [19:0] adc_q;
  logic [31:0] rem_q, quo_q, dvd_q;
  logic        hi_q;
  out_word_t   res_q;
  logic [32:0] rem_sh;
  logic [31:0] t1, p1;

  assign prod = a_q * b_q;
  assign t1 = {16'd0, tcal_q[15:0]};
  assign p1 = {16'd0, pca_q[15:0]};
  assign rem_sh = {rem_q, dvd_q[31]};
  assign status_o.div_zero = (y_q == 32'd0);
  assign result_o = res_q;

  // Calibration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcal_q <= '0; pca_q <= '0; pcb_q <= '0; pcc_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegTempCal:   tcal_q <= cfg_data_i;
        RegPressCalA: pca_q  <= cfg_data_i;
        RegPressCalB: pcb_q  <= cfg_data_i;
        RegPressCalC: pcc_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Fine temperature state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tfine_q <= '0;
    end else if (op_i == OpT3) begin
      tfine_q <= x1_q + sar32(prod, 14);
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      adc_q <= raw_i;
    end
    case (op_i)
      OpTLoad: begin
        a_q  <= sar32({12'd0, adc_q}, 3) - (t1 << 1);
        b_q  <= sw(tcal_q, 1);
        x2_q <= sar32({12'd0, adc_q}, 4) - t1;
      end
      OpT1: begin
        x1_q <= sar32(prod, 11);
        a_q  <= x2_q;
        b_q  <= x2_q;
      end
      OpT2: begin
        a_q <= sar32(prod, 12);
        b_q <= sw(tcal_q, 2);
      end
      OpT3: begin
        a_q <= x1_q + sar32(prod, 14);
        b_q <= 32'd5;
      end
      OpT4: begin
        res_q.result_kind       <= CmdTemp;
        res_q.temperature_centi <= sar32(prod + 32'd128, 8);
        res_q.pressure_pa       <= '0;
        res_q.divisor_zero      <= 1'b0;
      end
      OpPLoad: begin
        x1_q <= sar32(tfine_q, 1) - 32'd64000;
        a_q  <= sar32(sar32(tfine_q, 1) - 32'd64000, 2);
        b_q  <= sar32(sar32(tfine_q, 1) - 32'd64000, 2);
      end
      OpP1: begin
        sq_q <= prod;
        a_q  <= sar32(prod, 11);
        b_q  <= sw(pcb_q, 2);
      end
      OpP2: begin
        x2_q <= prod;
        a_q  <= x1_q;
        b_q  <= sw(pcb_q, 1);
      end
      OpP3: begin
        x2_q <= sar32(x2_q + (prod << 1), 2) + (sw(pcb_q, 0) << 16);
        a_q  <= sw(pca_q, 2);
        b_q  <= sar32(sq_q, 13);
      end
      OpP4: begin
        y_q <= sar32(prod, 3);
        a_q <= sw(pca_q, 1);
        b_q <= x1_q;
      end
      OpP5: begin
        y_q <= sar32(y_q + sar32(prod, 1), 18) + 32'd32768;
        a_q <= sar32(y_q + sar32(prod, 1), 18) + 32'd32768;
        b_q <= p1;
      end
      OpP6: begin
        y_q <= sar32(prod, 15);
        a_q <= (32'd1048576 - {12'd0, adc_q}) - sar32(x2_q, 12);
        b_q <= 32'd3125;
      end
      OpP7: begin
        hi_q  <= prod[31];
        dvd_q <= prod[31] ? prod : (prod << 1);
        rem_q <= '0;
        quo_q <= '0;
      end
      OpDiv: begin
        if (rem_sh >= {1'b0, y_q}) begin
          rem_q <= 32'(rem_sh - {1'b0, y_q});
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= rem_sh[31:0];
          quo_q <= {quo_q[30:0], 1'b0};
        end
        dvd_q <= dvd_q << 1;
      end
      OpP8: begin
        p_q <= hi_q ? (quo_q << 1) : quo_q;
        a_q <= (hi_q ? (quo_q << 1) : quo_q) >> 3;
        b_q <= (hi_q ? (quo_q << 1) : quo_q) >> 3;
      end
      OpP9: begin
        a_q <= prod >> 13;
        b_q <= sw(pcc_q, 2);
      end
      OpP10: begin
        x1_q <= sar32(prod, 12);
        a_q  <= p_q >> 2;
        b_q  <= sw(pcc_q, 1);
      end
      OpP11: begin
        res_q.result_kind       <= CmdPress;
        res_q.temperature_centi <= '0;
        res_q.pressure_pa  <= p_q + sar32(x1_q + sar32(prod, 13) + sw(pcc_q, 0), 4);
        res_q.divisor_zero <= 1'b0;
      end
      default: ;
    endcase
    // Zero divisor: at OpP7 the controller skips the divide and goes straight to output
    if (op_i == OpP7 && y_q == 32'd0) begin
      res_q.result_kind       <= CmdPress;
      res_q.temperature_centi <= '0;
      res_q.pressure_pa       <= '0;
      res_q.divisor_zero      <= 1'b1;
    end
  end

endmodule

// ===== design/ptc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptc_ctrl
// Sequencer: steps the datapath through the temperature or pressure formula.
// ----------------------------------------------------------------------------
module ptc_ctrl import ptc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_cmd_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output logic       load_o,
  output op_e        op_o
);

  typedef enum logic [1:0] {SIdle, SRun, SOut} state_e;

  state_e      state_q;
  op_e         op_q;
  logic [4:0]  cnt_q;
  logic        acc;

  assign acc        = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != SIdle);
  assign out_valid_o = (state_q == SOut);
  assign load_o     = acc;
  assign op_o       = (state_q == SRun) ? op_q : OpNone;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      op_q    <= OpNone;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        SIdle: if (acc) begin
          state_q <= SRun;
          op_q    <= (in_cmd_i == CmdTemp) ? OpTLoad : OpPLoad;
        end
        SRun: begin
          case (op_q)
            OpTLoad: op_q <= OpT1;
            OpT1:    op_q <= OpT2;
            OpT2:    op_q <= OpT3;
            OpT3:    op_q <= OpT4;
            OpPLoad: op_q <= OpP1;
            OpP1:    op_q <= OpP2;
            OpP2:    op_q <= OpP3;
            OpP3:    op_q <= OpP4;
            OpP4:    op_q <= OpP5;
            OpP5:    op_q <= OpP6;
            OpP6:    op_q <= OpP7;
            OpP7: begin
              if (status_i.div_zero) begin
                state_q <= SOut;
              end else begin
                op_q  <= OpDiv;
                cnt_q <= '0;
              end
            end
            OpDiv: begin
              cnt_q <= cnt_q + 5'd1;
              if (cnt_q == 5'd31) op_q <= OpP8;
            end
            OpP8:  op_q <= OpP9;
            OpP9:  op_q <= OpP10;
            OpP10: op_q <= OpP11;
            default: state_q <= SOut;  // OpT4, OpP11
          endcase
        end
        SOut: if (!out_stall_i) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> !load_o) else $error("accept while busy");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SRun && op_q == OpDiv) |-> (cnt_q <= 5'd31)) else $error("div count");
`endif

endmodule

// ===== design/pressure_temperature_compensation_core.sv =====
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_core
// Integer compensation of raw 20-bit temperature and pressure readings.
// ----------------------------------------------------------------------------
// channel | direction | handshake           | word
// in      | input     | in_valid_i/stall_o  | in_word_t (command, raw_sample)
// out     | output    | out_valid_o/stall_i | out_word_t
// cfg     | input     | cfg_we_i            | 48-bit calibration register
//
// Temperature word: 5 sequencer steps, then the result is valid in the output state.
// Pressure word: 8 setup steps, 32 divide steps and 4 correction steps, then the
// result is valid in the output state. A zero divisor skips the rest.
// One word is in flight at a time.
// Reset clears calibration and the fine-temperature term.
// A stalled result holds; input stays stalled until the result is taken.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_core import ptc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [IdxWidth-1:0] cfg_idx_i,
  input  logic [CalWidth-1:0] cfg_data_i
);

  dp_status_t status;
  logic       load;
  op_e        op;

  ptc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_cmd_i(in_data_i.command), .in_stall_o,
    .out_valid_o, .out_stall_i, .status_i(status), .load_o(load), .op_o(op)
  );

  ptc_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .load_i(load),
    .raw_i(in_data_i.raw_sample), .op_i(op), .status_o(status), .result_o(out_data_o)
  );

endmodule
